FILE: sv/stereo_feedback_delay_defines.svh
// Assertion macros shared by the stereo feedback delay RTL.
`ifndef STEREO_FEEDBACK_DELAY_DEFINES_SVH
`define STEREO_FEEDBACK_DELAY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SFD_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stereo_feedback_delay: assertion failed");
`define SFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stereo_feedback_delay: assertion failed");
`else
`define SFD_ASSERT_NOW(name, ante, cons)
`define SFD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: sv/sfd_pkg.sv
// Types and constants shared by the stereo feedback delay modules.
package sfd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 8;
    localparam int LEN_BITS    = 16;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    // Mixer datapath widths: coefficient times sample, then a two-term sum.
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS  = SUM_BITS - 1;

    // Division by 255 through the reciprocal (2^24 - 1) / 255 with one correction step.
    localparam int RECIP_BITS = 17;
    localparam logic [RECIP_BITS-1:0] RECIP = 17'h10101;
    localparam int DIV_SHIFT  = 24;
    localparam int QUOT_BITS  = MAG_BITS + RECIP_BITS - DIV_SHIFT;
    localparam int COEF_MAX   = 255;

    localparam int SAT_POS_MAG = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAT_NEG_MAG = 2 ** (SAMPLE_BITS - 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_DRY      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WET      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STORE    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_L    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN_R    = 3'd5;

    localparam logic [COEF_BITS-1:0] COEF_RESET = 8'd128;
    localparam logic [LEN_BITS-1:0]  LEN_RESET  = 16'h8000;

    typedef struct packed {
        logic [COEF_BITS-1:0] dry;
        logic [COEF_BITS-1:0] wet;
        logic [COEF_BITS-1:0] store;
        logic [COEF_BITS-1:0] feedback;
    } sfd_coef_t;

    // Pipeline control from the top level to each lane.
    typedef struct packed {
        logic accept;
        logic adv1;
        logic adv2;
        logic adv3;
        logic v1;
        logic v2;
        logic v3;
    } sfd_ctrl_t;

endpackage

FILE: sv/sfd_mix.sv
// Two-stage divide-by-255 with truncation toward zero and saturation to the sample range.
module sfd_mix
    import sfd_pkg::*;
(
    input  logic                          clk,
    input  logic                          ld2,
    input  logic                          ld3,
    input  logic signed [SUM_BITS-1:0]    sum_in,
    output logic signed [SAMPLE_BITS-1:0] result
);

    logic signed [SUM_BITS-1:0]           sum_reg;
    logic        [SUM_BITS-1:0]           mag_full;
    logic        [MAG_BITS-1:0]           mag;
    logic        [MAG_BITS+RECIP_BITS-1:0] est_full;
    logic        [QUOT_BITS-1:0]          q_est;

    logic        [QUOT_BITS-1:0]          q_reg;
    logic        [MAG_BITS-1:0]           mag_reg;
    logic                                 neg_reg;

    logic        [QUOT_BITS+COEF_BITS-1:0] prod255;
    logic        [QUOT_BITS+COEF_BITS-1:0] rem;
    logic        [QUOT_BITS-1:0]          q_fix;
    logic        [QUOT_BITS-1:0]          q_neg;

    always_comb
    begin
        mag_full = sum_reg[SUM_BITS-1] ? -sum_reg : sum_reg;
        mag      = mag_full[MAG_BITS-1:0];
        est_full = (MAG_BITS+RECIP_BITS)'(mag) * (MAG_BITS+RECIP_BITS)'(RECIP);
        q_est    = est_full[MAG_BITS+RECIP_BITS-1:DIV_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            sum_reg <= sum_in;
        end
        if (ld3)
        begin
            q_reg   <= q_est;
            mag_reg <= mag;
            neg_reg <= sum_reg[SUM_BITS-1];
        end
    end

    // The estimate is the true quotient or one below it.
    always_comb
    begin
        prod255 = {q_reg, {COEF_BITS{1'b0}}} - (QUOT_BITS+COEF_BITS)'(q_reg);
        rem     = (QUOT_BITS+COEF_BITS)'(mag_reg) - prod255;
        q_fix   = q_reg + QUOT_BITS'(rem >= (QUOT_BITS+COEF_BITS)'(COEF_MAX));
        q_neg   = -q_fix;
        if (neg_reg)
        begin
            if (q_fix > QUOT_BITS'(SAT_NEG_MAG))
            begin
                result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end
            else
            begin
                result = q_neg[SAMPLE_BITS-1:0];
            end
        end
        else
        begin
            if (q_fix > QUOT_BITS'(SAT_POS_MAG))
            begin
                result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end
            else
            begin
                result = q_fix[SAMPLE_BITS-1:0];
            end
        end
    end

endmodule

FILE: sv/sfd_lane.sv
// One channel of the echo: delay line memory, position counter and the two mixers.
module sfd_lane
    import sfd_pkg::*;
#(
    parameter int MAX_DELAY = 32768
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfd_ctrl_t                     ctrl,
    input  sfd_coef_t                     coef,
    input  logic                          active,
    input  logic [LEN_BITS-1:0]           length,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] result,
    output logic                          hazard
);

    localparam int AW  = $clog2(MAX_DELAY);
    localparam int LCW = (AW + 1 > LEN_BITS) ? AW + 1 : LEN_BITS;

    logic signed [SAMPLE_BITS-1:0] line_mem [0:MAX_DELAY-1];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    logic [AW-1:0]  pos_reg;
    logic [AW-1:0]  pos_next;
    logic [LCW-1:0] pos_inc;
    logic           wrap;
    // Entries at or above the fill mark have never been written and read as zero.
    logic [AW:0]    fill_reg;
    logic [AW:0]    fill_next;
    logic [AW:0]    wr_top;
    logic           wr_en;

    logic [AW-1:0]                 addr1_reg, addr2_reg, addr3_reg;
    logic signed [SAMPLE_BITS-1:0] in1_reg, in2_reg, in3_reg;
    logic                          act1_reg, act2_reg, act3_reg;
    logic                          zero1_reg;

    logic signed [SAMPLE_BITS-1:0] pv;
    logic signed [PROD_BITS-1:0]   p_fb, p_st, p_dry, p_wet;
    logic signed [SUM_BITS-1:0]    sum_store, sum_out;
    logic signed [SAMPLE_BITS-1:0] store_res, out_res;

    always_comb
    begin
        pos_inc  = LCW'(pos_reg) + LCW'(1);
        wrap     = (pos_inc >= LCW'(length)) || (pos_inc >= LCW'(MAX_DELAY));
        pos_next = wrap ? '0 : pos_inc[AW-1:0];
        wr_en    = ctrl.adv3 && act3_reg;
        wr_top   = {1'b0, addr3_reg} + (AW+1)'(1);
        fill_next = (wr_en && (wr_top > fill_reg)) ? wr_top : fill_reg;
        hazard   = active && ((ctrl.v1 && act1_reg && (addr1_reg == pos_reg)) ||
                              (ctrl.v2 && act2_reg && (addr2_reg == pos_reg)) ||
                              (ctrl.v3 && act3_reg && (addr3_reg == pos_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (ctrl.accept && active)
            begin
                pos_reg <= pos_next;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            rd_data_reg <= line_mem[pos_reg];
        end
        if (wr_en)
        begin
            line_mem[addr3_reg] <= store_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            addr1_reg <= pos_reg;
            in1_reg   <= sample;
            act1_reg  <= active;
            zero1_reg <= ({1'b0, pos_reg} >= fill_reg);
        end
        if (ctrl.adv1)
        begin
            addr2_reg <= addr1_reg;
            in2_reg   <= in1_reg;
            act2_reg  <= act1_reg;
        end
        if (ctrl.adv2)
        begin
            addr3_reg <= addr2_reg;
            in3_reg   <= in2_reg;
            act3_reg  <= act2_reg;
        end
    end

    always_comb
    begin
        pv        = zero1_reg ? '0 : rd_data_reg;
        p_fb      = $signed({1'b0, coef.feedback}) * pv;
        p_st      = $signed({1'b0, coef.store}) * in1_reg;
        p_dry     = $signed({1'b0, coef.dry}) * in1_reg;
        p_wet     = $signed({1'b0, coef.wet}) * pv;
        sum_store = SUM_BITS'(p_fb) + SUM_BITS'(p_st);
        sum_out   = SUM_BITS'(p_dry) + SUM_BITS'(p_wet);
    end

    sfd_mix u_mix_store (
        .clk    (clk),
        .ld2    (ctrl.adv1),
        .ld3    (ctrl.adv2),
        .sum_in (sum_store),
        .result (store_res)
    );

    sfd_mix u_mix_out (
        .clk    (clk),
        .ld2    (ctrl.adv1),
        .ld3    (ctrl.adv2),
        .sum_in (sum_out),
        .result (out_res)
    );

    // A channel in mono mode passes its sample through untouched.
    assign result = act3_reg ? out_res : in3_reg;

endmodule

FILE: sv/stereo_feedback_delay.sv
// Stereo feedback delay: a taken frame passes lane stages 1, 2 and 3, then the output register.
// Throughput is one frame per cycle while the output is not stalled; a frame waits while its line
// position has a write pending in the three-stage lane pipeline, so lengths up to three slow it.
// Reset empties the pipeline, zeroes positions and loads register defaults; line contents read
// as zero until written, tracked by a fill mark per line, so no clearing pass runs after reset.
`include "stereo_feedback_delay_defines.svh"
module stereo_feedback_delay
    import sfd_pkg::*;
#(
    parameter int MAX_DELAY = 32768
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_left,
    input  logic signed [SAMPLE_BITS-1:0] sample_right,
    input  logic                          block_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic                          block_last_out
);

    sfd_coef_t             coef_reg;
    logic [LEN_BITS-1:0]   len_l_reg;
    logic [LEN_BITS-1:0]   len_r_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic last1_reg, last2_reg, last3_reg;
    logic adv1, adv2, adv3;
    logic s1_free, s2_free, s3_free;
    logic accept;
    logic hazard_l, hazard_r;
    logic right_on;
    sfd_ctrl_t ctrl;

    logic signed [SAMPLE_BITS-1:0] res_l, res_r;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_right_reg;
    logic                          last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.dry      <= COEF_RESET;
            coef_reg.wet      <= COEF_RESET;
            coef_reg.store    <= COEF_RESET;
            coef_reg.feedback <= COEF_RESET;
            len_l_reg         <= LEN_RESET;
            len_r_reg         <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DRY:      coef_reg.dry      <= cfg_data[COEF_BITS-1:0];
                CFG_WET:      coef_reg.wet      <= cfg_data[COEF_BITS-1:0];
                CFG_STORE:    coef_reg.store    <= cfg_data[COEF_BITS-1:0];
                CFG_FEEDBACK: coef_reg.feedback <= cfg_data[COEF_BITS-1:0];
                CFG_LEN_L:    len_l_reg         <= cfg_data[LEN_BITS-1:0];
                CFG_LEN_R:    len_r_reg         <= cfg_data[LEN_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Each stage moves forward when the stage after it is empty or moving.
    always_comb
    begin
        adv3     = v3_reg && (!out_valid_reg || !out_stall);
        s3_free  = !v3_reg || adv3;
        adv2     = v2_reg && s3_free;
        s2_free  = !v2_reg || adv2;
        adv1     = v1_reg && s2_free;
        s1_free  = !v1_reg || adv1;
        in_stall = !s1_free || hazard_l || hazard_r;
        accept   = in_valid && !in_stall;
        right_on = (len_r_reg != '0);

        ctrl.accept = accept;
        ctrl.adv1   = adv1;
        ctrl.adv2   = adv2;
        ctrl.adv3   = adv3;
        ctrl.v1     = v1_reg;
        ctrl.v2     = v2_reg;
        ctrl.v3     = v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv1)
            begin
                v1_reg <= 1'b0;
            end
            if (adv1)
            begin
                v2_reg <= 1'b1;
            end
            else if (adv2)
            begin
                v2_reg <= 1'b0;
            end
            if (adv2)
            begin
                v3_reg <= 1'b1;
            end
            else if (adv3)
            begin
                v3_reg <= 1'b0;
            end
            if (adv3)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last1_reg <= block_last;
        end
        if (adv1)
        begin
            last2_reg <= last1_reg;
        end
        if (adv2)
        begin
            last3_reg <= last2_reg;
        end
        if (adv3)
        begin
            out_left_reg  <= res_l;
            out_right_reg <= res_r;
            last_out_reg  <= last3_reg;
        end
    end

    sfd_lane #(
        .MAX_DELAY (MAX_DELAY)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .coef   (coef_reg),
        .active (1'b1),
        .length (len_l_reg),
        .sample (sample_left),
        .result (res_l),
        .hazard (hazard_l)
    );

    sfd_lane #(
        .MAX_DELAY (MAX_DELAY)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .coef   (coef_reg),
        .active (right_on),
        .length (len_r_reg),
        .sample (sample_right),
        .result (res_r),
        .hazard (hazard_r)
    );

    assign out_valid      = out_valid_reg;
    assign out_left       = out_left_reg;
    assign out_right      = out_right_reg;
    assign block_last_out = last_out_reg;

    `SFD_ASSERT_NEXT(a_out_follows_s3, out_valid_reg && !out_stall, out_valid_reg == $past(v3_reg))
    `SFD_ASSERT_NEXT(a_s3_held, v3_reg && out_valid_reg && out_stall, v3_reg)
    `SFD_ASSERT_NEXT(a_s1_held, v1_reg && !adv1, v1_reg)
    `SFD_ASSERT_NOW(a_no_pending_read, accept, !hazard_l && !hazard_r && s1_free)

endmodule

FILE: tb/sv/stereo_feedback_delay_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stereo feedback delay, with its own echo predictor.
module stereo_feedback_delay_tb
    import sfd_pkg::*;
();

    localparam int LINE_DEPTH   = 32768;
    localparam int PHASES       = 10;
    localparam int PHASE_FRAMES = 110;
    localparam int MAX_REPORTS  = 10;

    // Indexes past the register list; writes to them must leave everything unchanged.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t S_MAX = 16'sh7fff;
    localparam sample_t S_MIN = 16'sh8000;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    last;
    } frame_t;

    typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_BITS-1:0] index;
        logic [CFG_BITS-1:0]     data;
        frame_t                  stim;
        logic                    typed;
        frame_t                  known;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    sample_t                 sample_left;
    sample_t                 sample_right;
    logic                    block_last;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    sample_t                 out_left;
    sample_t                 out_right;
    logic                    block_last_out;

    stereo_feedback_delay uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_left    (sample_left),
        .sample_right   (sample_right),
        .block_last     (block_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_left       (out_left),
        .out_right      (out_right),
        .block_last_out (block_last_out)
    );

    // Predictor state: one delay line and position per channel, plus the register mirror.
    sample_t             delay_mem [2][LINE_DEPTH];
    int unsigned         lane_pos [2];
    int unsigned         coef_dry;
    int unsigned         coef_wet;
    int unsigned         coef_store;
    int unsigned         coef_feedback;
    logic [LEN_BITS-1:0] len_cfg [2];

    frame_t due_frames [$];
    int     fault_count = 0;
    int     rx_hold = 0;
    logic   tx_quiet = 1'b0;
    logic   rx_quiet = 1'b0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic sample_t weigh_sum(int unsigned ka, longint a, int unsigned kb, longint b);
        longint s;
        s = (longint'(ka) * a + longint'(kb) * b) / 255;
        if (s > SAT_POS_MAG)
            s = SAT_POS_MAG;
        else if (s < -longint'(SAT_NEG_MAG))
            s = -longint'(SAT_NEG_MAG);
        return sample_t'(s);
    endfunction

    function automatic sample_t echo_lane(int ch, int unsigned span, sample_t in_s);
        int unsigned p;
        sample_t     held;
        p = lane_pos[ch] % LINE_DEPTH;
        held = delay_mem[ch][p];
        delay_mem[ch][p] = weigh_sum(coef_feedback, held, coef_store, in_s);
        p++;
        // A position left beyond a shrunken length still gets used once, then wraps.
        lane_pos[ch] = (p >= span) ? 0 : p;
        return weigh_sum(coef_dry, in_s, coef_wet, held);
    endfunction

    function automatic frame_t echo_step(frame_t stim);
        frame_t      res;
        int unsigned span_l;
        int unsigned span_r;
        span_l = (len_cfg[0] > LINE_DEPTH) ? LINE_DEPTH : len_cfg[0];
        span_r = (len_cfg[1] > LINE_DEPTH) ? LINE_DEPTH : len_cfg[1];
        if (span_l == 0)
            span_l = 1;
        res.left = echo_lane(0, span_l, stim.left);
        if (span_r == 0)
            res.right = stim.right;
        else
            res.right = echo_lane(1, span_r, stim.right);
        res.last = stim.last;
        return res;
    endfunction

    function automatic row_t frame_row(sample_t l, sample_t r, logic last, logic typed,
                                       sample_t kl, sample_t kr);
        row_t row;
        row = '0;
        row.kind = ROW_FRAME;
        row.stim.left = l;
        row.stim.right = r;
        row.stim.last = last;
        row.typed = typed;
        row.known.left = kl;
        row.known.right = kr;
        row.known.last = last;
        return row;
    endfunction

    function automatic row_t cfg_row(logic [CFG_IDX_BITS-1:0] index, logic [CFG_BITS-1:0] data);
        row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.index = index;
        row.data = data;
        return row;
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return sample_t'(0);
            3: return sample_t'(-1);
            default: return sample_t'(16'($urandom));
        endcase
    endfunction

    // Upper byte is random so that the register masking is exercised too.
    function automatic logic [CFG_BITS-1:0] pick_coef();
        logic [COEF_BITS-1:0] c;
        case ($urandom_range(0, 3))
            0: c = '0;
            1: c = 8'hff;
            default: c = 8'($urandom);
        endcase
        return {8'($urandom), c};
    endfunction

    // Mostly short lines so the echo comes back many times within a phase.
    function automatic logic [CFG_BITS-1:0] pick_length();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'($urandom_range(2, 3));
            3: return LEN_RESET;
            4: return 16'($urandom_range(32769, 65535));
            5: return 16'($urandom_range(1, 32768));
            default: return 16'($urandom_range(4, 64));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] index, logic [CFG_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        case (index)
            CFG_DRY:      coef_dry = data[COEF_BITS-1:0];
            CFG_WET:      coef_wet = data[COEF_BITS-1:0];
            CFG_STORE:    coef_store = data[COEF_BITS-1:0];
            CFG_FEEDBACK: coef_feedback = data[COEF_BITS-1:0];
            CFG_LEN_L:    len_cfg[0] = data;
            CFG_LEN_R:    len_cfg[1] = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Registers only change once the pipeline has drained.
    task automatic settle();
        in_valid <= 1'b0;
        wait (due_frames.size() == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_frame(frame_t stim, logic typed, frame_t known);
        int     gap;
        frame_t due;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_left <= stim.left;
        sample_right <= stim.right;
        block_last <= stim.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        due = echo_step(stim);
        due_frames.push_back(typed ? known : due);
        @(negedge clk);
    endtask

    // Each accepted output transaction draws how many cycles the sink then holds off.
    always @(posedge clk)
    begin : watch_out
        frame_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_frames.size() == 0)
            begin
                if (fault_count < MAX_REPORTS)
                    $display("unexpected transaction: %0d %0d %0b",
                             out_left, out_right, block_last_out);
                fault_count++;
            end
            else
            begin
                due = due_frames.pop_front();
                if (out_left !== due.left || out_right !== due.right ||
                    block_last_out !== due.last)
                begin
                    if (fault_count < MAX_REPORTS)
                        $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                 due.left, due.right, due.last,
                                 out_left, out_right, block_last_out);
                    fault_count++;
                end
            end
            rx_hold = rx_quiet ? 0 : $urandom_range(0, 11);
        end
        else if (rx_hold > 0)
            rx_hold = rx_hold - 1;
    end

    always @(negedge clk)
    begin
        out_stall <= (rx_hold > 0);
    end

    initial
    begin : stimulus
        row_t   plan [$];
        frame_t stim;
        logic   cfg_open;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_left = '0;
        sample_right = '0;
        block_last = 1'b0;
        cfg_open = 1'b0;
        foreach (delay_mem[c, i])
            delay_mem[c][i] = '0;
        lane_pos[0] = 0;
        lane_pos[1] = 0;
        coef_dry = COEF_RESET;
        coef_wet = COEF_RESET;
        coef_store = COEF_RESET;
        coef_feedback = COEF_RESET;
        len_cfg[0] = LEN_RESET;
        len_cfg[1] = LEN_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register values straight out of reset.
        plan.push_back(frame_row(16'sd100, -16'sd100, 1'b0, 1'b0, '0, '0));
        plan.push_back(frame_row(S_MAX, S_MIN, 1'b1, 1'b0, '0, '0));
        // Full weights, left length zero acts as one, right in mono, spare indexes ignored.
        plan.push_back(cfg_row(CFG_DRY, 16'hffff));
        plan.push_back(cfg_row(CFG_WET, 16'h00ff));
        plan.push_back(cfg_row(CFG_STORE, 16'h7fff));
        plan.push_back(cfg_row(CFG_FEEDBACK, 16'h80ff));
        plan.push_back(cfg_row(CFG_LEN_L, 16'h0000));
        plan.push_back(cfg_row(CFG_LEN_R, 16'h0000));
        plan.push_back(cfg_row(CFG_SPARE_A, 16'h1234));
        plan.push_back(cfg_row(CFG_SPARE_B, 16'hffff));
        // The left position sits past the new length here and reads a never-written entry as zero.
        plan.push_back(frame_row(16'sd0, 16'sh5555, 1'b0, 1'b1, 16'sd0, 16'sh5555));
        plan.push_back(frame_row(-16'sd50, 16'shaaaa, 1'b0, 1'b0, '0, '0));
        // One-frame loop with unity weights: the line accumulates and saturates.
        plan.push_back(frame_row(S_MAX, 16'sd1, 1'b1, 1'b1, S_MAX, 16'sd1));
        plan.push_back(frame_row(S_MAX, -16'sd2, 1'b0, 1'b1, S_MAX, -16'sd2));
        plan.push_back(frame_row(S_MIN, S_MAX, 1'b0, 1'b1, -16'sd1, S_MAX));
        plan.push_back(frame_row(S_MIN, S_MIN, 1'b0, 1'b1, S_MIN, S_MIN));
        plan.push_back(frame_row(S_MIN, 16'sd0, 1'b1, 1'b1, S_MIN, 16'sd0));
        plan.push_back(frame_row(16'sd0, 16'sh1234, 1'b0, 1'b1, S_MIN, 16'sh1234));
        // Zero weights silence both channels; oversized lengths clamp to the line depth.
        plan.push_back(cfg_row(CFG_DRY, 16'hff00));
        plan.push_back(cfg_row(CFG_WET, 16'h0000));
        plan.push_back(cfg_row(CFG_STORE, 16'h5500));
        plan.push_back(cfg_row(CFG_FEEDBACK, 16'h0000));
        plan.push_back(cfg_row(CFG_LEN_L, 16'hffff));
        plan.push_back(cfg_row(CFG_LEN_R, 16'h8001));
        plan.push_back(frame_row(S_MAX, S_MIN, 1'b1, 1'b1, 16'sd0, 16'sd0));
        plan.push_back(frame_row(S_MIN, S_MAX, 1'b0, 1'b1, 16'sd0, 16'sd0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    settle();
                cfg_open = 1'b1;
                write_reg(plan[i].index, plan[i].data);
            end
            else
            begin
                if (cfg_open)
                    cfg_write <= 1'b0;
                cfg_open = 1'b0;
                send_frame(plan[i].stim, plan[i].typed, plan[i].known);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            write_reg(CFG_DRY, pick_coef());
            write_reg(CFG_WET, pick_coef());
            write_reg(CFG_STORE, pick_coef());
            write_reg(CFG_FEEDBACK, pick_coef());
            write_reg(CFG_LEN_L, pick_length());
            write_reg(CFG_LEN_R, pick_length());
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
            cfg_write <= 1'b0;
            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                stim.left = pick_sample();
                stim.right = pick_sample();
                stim.last = 1'($urandom_range(0, 1));
                send_frame(stim, 1'b0, stim);
            end
        end

        in_valid <= 1'b0;
        wait (due_frames.size() == 0);
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/sfd_pkg.sv
sv/sfd_mix.sv
sv/sfd_lane.sv
sv/stereo_feedback_delay.sv
tb/sv/stereo_feedback_delay_tb.sv
